// File: hdl/rvie_pkg.sv
// Shared opcodes, status codes and ALU helper for the RV32IMA executor.
package rvie_pkg;

  localparam logic [6:0] OP_LUI    = 7'b0110111;
  localparam logic [6:0] OP_AUIPC  = 7'b0010111;
  localparam logic [6:0] OP_OP     = 7'b0110011;
  localparam logic [6:0] OP_IMM    = 7'b0010011;
  localparam logic [6:0] OP_LOAD   = 7'b0000011;
  localparam logic [6:0] OP_STORE  = 7'b0100011;
  localparam logic [6:0] OP_JAL    = 7'b1101111;
  localparam logic [6:0] OP_JALR   = 7'b1100111;
  localparam logic [6:0] OP_BRANCH = 7'b1100011;
  localparam logic [6:0] OP_AMO    = 7'b0101111;
  localparam logic [6:0] OP_FENCE  = 7'b0001111;
  localparam logic [6:0] OP_SYSTEM = 7'b1110011;

  localparam logic [6:0] F7_BASE   = 7'h00;
  localparam logic [6:0] F7_ALT    = 7'h20;
  localparam logic [6:0] F7_MULDIV = 7'h01;

  localparam logic [4:0] AMO_ADD  = 5'd0;
  localparam logic [4:0] AMO_SWAP = 5'd1;
  localparam logic [4:0] AMO_LR   = 5'd2;
  localparam logic [4:0] AMO_SC   = 5'd3;
  localparam logic [4:0] AMO_XOR  = 5'd4;
  localparam logic [4:0] AMO_OR   = 5'd8;
  localparam logic [4:0] AMO_AND  = 5'd12;
  localparam logic [4:0] AMO_MIN  = 5'd16;
  localparam logic [4:0] AMO_MAX  = 5'd20;
  localparam logic [4:0] AMO_MINU = 5'd24;
  localparam logic [4:0] AMO_MAXU = 5'd28;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_PASS    = 3'd1;
  localparam logic [2:0] ST_FAIL    = 3'd2;
  localparam logic [2:0] ST_ILLEGAL = 3'd3;
  localparam logic [2:0] ST_FAULT   = 3'd4;

  localparam logic        CFG_START = 1'b0;
  localparam logic        CFG_BASE  = 1'b1;
  localparam logic [11:0] CSR_CYCLE = 12'hB00;
  localparam logic [31:0] PASS_CODE = 32'h0000002A;
  localparam logic [4:0]  REG_A0    = 5'd10;
  localparam logic [31:0] UPPER_MASK = 32'hFFFFF000;

  // base integer ALU; alt selects SUB / SRA
  function automatic logic [31:0] alu_calc(input logic [2:0] f3, input logic alt,
                                           input logic [31:0] a, input logic [31:0] b);
    logic [4:0] sh;
    logic [31:0] res;
    sh = b[4:0];
    case (f3)
      3'd0: res = alt ? (a - b) : (a + b);
      3'd1: res = a << sh;
      3'd2: res = {31'b0, ($signed(a) < $signed(b))};
      3'd3: res = {31'b0, (a < b)};
      3'd4: res = a ^ b;
      3'd5: res = alt ? 32'($signed(a) >>> sh) : (a >> sh);
      3'd6: res = a | b;
      default: res = a & b;
    endcase
    return res;
  endfunction

endpackage

// File: hdl/rv32ima_instruction_execute.sv
// RV32IMA executor top level: register file, CSR and data memories, sequencer.
//
// Executes one RV32IMA instruction word per input transaction and returns one
// result transaction (pc, next pc, destination write, status). After reset a
// clearing pass zeroes the data and CSR memories; no instruction is taken
// during it. Then each instruction goes accept, register read, execute,
// writeback. Loads, stores, atomics and CSR operations add a memory state for
// the synchronous memory read, multiplies add a finish state for the
// registered product, and divides and remainders go through the
// one-bit-per-cycle restoring divider and then the finish state. A divide by
// zero skips the divider. The result sits in an output register, so the next
// instruction is taken while a finished transaction waits. The cycle CSR
// (0xB00) is held in a counter and advances on every accepted instruction.
// Configuration: index 0 sets the boot pc (and the current pc), index 1 sets
// the base of the data window.
module rv32ima_instruction_execute
  import rvie_pkg::*;
#(
  parameter int DATA_WORDS = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_instr,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_instr_pc,
  output logic [31:0] out_next_pc,
  output logic        out_rd_written,
  output logic [4:0]  out_rd_index,
  output logic [31:0] out_rd_value,
  output logic [2:0]  out_status
);

  localparam int CSR_ENTRIES = 4096;
  localparam int GP_REGS     = 32;
  localparam int AW          = $clog2(DATA_WORDS);
  localparam int CLR_N       = (DATA_WORDS > CSR_ENTRIES) ? DATA_WORDS : CSR_ENTRIES;
  localparam int CW          = $clog2(CLR_N);
  localparam logic [CW-1:0] CLR_LAST = CW'(CLR_N - 1);
  localparam logic [31:0]   WIN_BYTES = 32'(DATA_WORDS * 4);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_EX   = 3'd3;
  localparam logic [2:0] S_MEM  = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;
  localparam logic [2:0] S_WB   = 3'd7;

  // memories
  logic [31:0] rf_mem   [GP_REGS];
  logic [31:0] csr_mem  [CSR_ENTRIES];
  logic [31:0] dmem     [DATA_WORDS];
  logic [GP_REGS-1:0] rf_vld_r, rf_vld_nxt;

  logic [31:0] rfa_q, rfb_q, csr_q, dm_q;
  logic        rfa_v, rfb_v;

  logic          rf_we;
  logic [4:0]    rf_waddr;
  logic [31:0]   rf_wdata;
  logic          csr_we;
  logic [11:0]   csr_waddr;
  logic [31:0]   csr_wdata;
  logic          dm_we;
  logic [AW-1:0] dm_waddr;
  logic [31:0]   dm_wdata;

  // control and datapath registers
  logic [2:0]  state_r, state_nxt;
  logic [CW-1:0] clr_r, clr_nxt;
  logic [31:0] instr_r, instr_nxt;
  logic [31:0] pc_r, pc_nxt;
  logic [31:0] start_r, start_nxt;
  logic [31:0] base_r, base_nxt;
  logic [31:0] cycle_r, cycle_nxt;
  logic        resv_v_r, resv_v_nxt;
  logic [31:0] resv_a_r, resv_a_nxt;
  logic [31:0] val_r, val_nxt;
  logic [31:0] tgt_r, tgt_nxt;
  logic [2:0]  st_r, st_nxt;
  logic        wr_r, wr_nxt;
  logic signed [65:0] prod_r, prod_nxt;
  logic [31:0] dq_r, dq_nxt, dr_r, dr_nxt, dd_r, dd_nxt;
  logic        dna_r, dna_nxt, dnb_r, dnb_nxt;
  logic [4:0]  dcnt_r, dcnt_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_pc_r, out_pc_nxt, out_npc_r, out_npc_nxt, out_val_r, out_val_nxt;
  logic        out_wr_r, out_wr_nxt;
  logic [4:0]  out_idx_r, out_idx_nxt;
  logic [2:0]  out_st_r, out_st_nxt;

  // instruction fields
  logic [6:0]  opc, f7;
  logic [4:0]  rd, rs1, rs2, f5;
  logic [2:0]  f3;
  logic [11:0] csr_idx;
  logic [31:0] imm_i, imm_s, imm_b, imm_j, imm_u;
  logic        is_ecall;
  logic [4:0]  ra_addr;
  logic [31:0] a, b;

  assign opc     = instr_r[6:0];
  assign rd      = instr_r[11:7];
  assign f3      = instr_r[14:12];
  assign rs1     = instr_r[19:15];
  assign rs2     = instr_r[24:20];
  assign f7      = instr_r[31:25];
  assign f5      = instr_r[31:27];
  assign csr_idx = instr_r[31:20];
  assign imm_i   = {{20{instr_r[31]}}, instr_r[31:20]};
  assign imm_s   = {{20{instr_r[31]}}, instr_r[31:25], instr_r[11:7]};
  assign imm_b   = {{20{instr_r[31]}}, instr_r[7], instr_r[30:25], instr_r[11:8], 1'b0};
  assign imm_j   = {{12{instr_r[31]}}, instr_r[19:12], instr_r[20], instr_r[30:21], 1'b0};
  assign imm_u   = instr_r & UPPER_MASK;

  // ECALL looks at a0 through the rs1 read port
  assign is_ecall = (opc == OP_SYSTEM) && (f3 == 3'd0) && (csr_idx == 12'd0);
  assign ra_addr  = is_ecall ? REG_A0 : rs1;

  assign a = rfa_v ? rfa_q : 32'd0;
  assign b = rfb_v ? rfb_q : 32'd0;

  // data address path
  logic [31:0] mem_addr, mem_off;
  logic        misal, mem_ok;
  logic [4:0]  sh5;
  logic [AW-1:0] widx;

  always_comb begin
    if (opc == OP_AMO) begin
      mem_addr = a;
    end else if (opc == OP_STORE) begin
      mem_addr = a + imm_s;
    end else begin
      mem_addr = a + imm_i;
    end
  end

  assign mem_off = mem_addr - base_r;
  assign misal   = ((f3[1:0] == 2'd1) && mem_addr[0]) ||
                   ((f3[1:0] == 2'd2) && (mem_addr[1:0] != 2'd0));
  assign mem_ok  = !misal && (mem_off < WIN_BYTES);
  assign sh5     = {mem_off[1:0], 3'b000};
  assign widx    = mem_off[AW+1:2];

  // memory-stage helpers
  logic [31:0] ld_sh, st_mask, st_merge, amo_new, csr_old, csr_src, csr_new;
  logic        amo_lt, amo_ltu;

  assign ld_sh = dm_q >> sh5;

  always_comb begin
    case (f3[1:0])
      2'd0:    st_mask = 32'h000000FF << sh5;
      2'd1:    st_mask = 32'h0000FFFF << sh5;
      default: st_mask = 32'hFFFFFFFF;
    endcase
  end

  assign st_merge = (dm_q & ~st_mask) | ((b << sh5) & st_mask);
  assign amo_lt   = $signed(dm_q) < $signed(b);
  assign amo_ltu  = dm_q < b;

  always_comb begin
    case (f5)
      AMO_SWAP: amo_new = b;
      AMO_XOR:  amo_new = dm_q ^ b;
      AMO_AND:  amo_new = dm_q & b;
      AMO_OR:   amo_new = dm_q | b;
      AMO_MIN:  amo_new = amo_lt ? dm_q : b;
      AMO_MAX:  amo_new = amo_lt ? b : dm_q;
      AMO_MINU: amo_new = amo_ltu ? dm_q : b;
      AMO_MAXU: amo_new = amo_ltu ? b : dm_q;
      default:  amo_new = dm_q + b;
    endcase
  end

  // cycle CSR lives in its own counter
  assign csr_old = (csr_idx == CSR_CYCLE) ? cycle_r : csr_q;
  assign csr_src = f3[2] ? {27'd0, rs1} : a;

  always_comb begin
    case (f3[1:0])
      2'd1:    csr_new = csr_src;
      2'd2:    csr_new = csr_old | csr_src;
      default: csr_new = csr_old & ~csr_src;
    endcase
  end

  // divider step
  logic [33:0] dtrial;
  logic [31:0] div_res;
  assign dtrial  = {1'b0, dr_r, dq_r[31]} - {2'b00, dd_r};
  assign div_res = f3[1] ? (dna_r ? (32'd0 - dr_r) : dr_r)
                         : ((dna_r != dnb_r) ? (32'd0 - dq_r) : dq_r);

  logic out_free;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    instr_nxt     = instr_r;
    pc_nxt        = pc_r;
    start_nxt     = start_r;
    base_nxt      = base_r;
    cycle_nxt     = cycle_r;
    resv_v_nxt    = resv_v_r;
    resv_a_nxt    = resv_a_r;
    val_nxt       = val_r;
    tgt_nxt       = tgt_r;
    st_nxt        = st_r;
    wr_nxt        = wr_r;
    prod_nxt      = prod_r;
    dq_nxt        = dq_r;
    dr_nxt        = dr_r;
    dd_nxt        = dd_r;
    dna_nxt       = dna_r;
    dnb_nxt       = dnb_r;
    dcnt_nxt      = dcnt_r;
    rf_vld_nxt    = rf_vld_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_pc_nxt    = out_pc_r;
    out_npc_nxt   = out_npc_r;
    out_val_nxt   = out_val_r;
    out_wr_nxt    = out_wr_r;
    out_idx_nxt   = out_idx_r;
    out_st_nxt    = out_st_r;
    rf_we         = 1'b0;
    rf_waddr      = rd;
    rf_wdata      = val_r;
    csr_we        = 1'b0;
    csr_waddr     = csr_idx;
    csr_wdata     = csr_new;
    dm_we         = 1'b0;
    dm_waddr      = widx;
    dm_wdata      = st_merge;

    unique case (state_r)
      S_CLR: begin
        dm_we     = 32'(clr_r) < 32'(DATA_WORDS);
        dm_waddr  = clr_r[AW-1:0];
        dm_wdata  = 32'd0;
        csr_we    = 32'(clr_r) < 32'(CSR_ENTRIES);
        csr_waddr = clr_r[11:0];
        csr_wdata = 32'd0;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == CLR_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          instr_nxt = in_instr;
          cycle_nxt = cycle_r + 32'd1;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_EX;
      end
      S_EX: begin
        val_nxt   = 32'd0;
        st_nxt    = ST_OK;
        wr_nxt    = 1'b0;
        tgt_nxt   = pc_r + 32'd4;
        state_nxt = S_WB;
        unique case (opc)
          OP_LUI: begin
            val_nxt = imm_u;
            wr_nxt  = 1'b1;
          end
          OP_AUIPC: begin
            val_nxt = pc_r + imm_u;
            wr_nxt  = 1'b1;
          end
          OP_OP: begin
            if (f7 == F7_MULDIV) begin
              if (!f3[2]) begin
                prod_nxt  = $signed({(f3 == 3'd1 || f3 == 3'd2) && a[31], a}) *
                            $signed({(f3 == 3'd1) && b[31], b});
                state_nxt = S_FIN;
              end else if (b == 32'd0) begin
                val_nxt = f3[1] ? a : 32'hFFFFFFFF;
                wr_nxt  = 1'b1;
              end else begin
                dna_nxt   = !f3[0] && a[31];
                dnb_nxt   = !f3[0] && b[31];
                dq_nxt    = (!f3[0] && a[31]) ? (32'd0 - a) : a;
                dd_nxt    = (!f3[0] && b[31]) ? (32'd0 - b) : b;
                dr_nxt    = 32'd0;
                dcnt_nxt  = 5'd0;
                state_nxt = S_DIV;
              end
            end else if ((f7 == F7_BASE) ||
                         ((f7 == F7_ALT) && ((f3 == 3'd0) || (f3 == 3'd5)))) begin
              val_nxt = alu_calc(f3, f7 == F7_ALT, a, b);
              wr_nxt  = 1'b1;
            end else begin
              st_nxt = ST_ILLEGAL;
            end
          end
          OP_IMM: begin
            if (f3 == 3'd1) begin
              if (f7 != F7_BASE) begin
                st_nxt = ST_ILLEGAL;
              end else begin
                val_nxt = alu_calc(f3, 1'b0, a, {27'd0, rs2});
                wr_nxt  = 1'b1;
              end
            end else if (f3 == 3'd5) begin
              if ((f7 != F7_BASE) && (f7 != F7_ALT)) begin
                st_nxt = ST_ILLEGAL;
              end else begin
                val_nxt = alu_calc(f3, f7 == F7_ALT, a, {27'd0, rs2});
                wr_nxt  = 1'b1;
              end
            end else begin
              val_nxt = alu_calc(f3, 1'b0, a, imm_i);
              wr_nxt  = 1'b1;
            end
          end
          OP_LOAD: begin
            if ((f3 == 3'd3) || (f3 == 3'd6) || (f3 == 3'd7)) begin
              st_nxt = ST_ILLEGAL;
            end else if (!mem_ok) begin
              st_nxt = ST_FAULT;
            end else begin
              state_nxt = S_MEM;
            end
          end
          OP_STORE: begin
            if (f3 > 3'd2) begin
              st_nxt = ST_ILLEGAL;
            end else if (!mem_ok) begin
              st_nxt = ST_FAULT;
            end else begin
              state_nxt = S_MEM;
            end
          end
          OP_JAL: begin
            val_nxt = pc_r + 32'd4;
            wr_nxt  = 1'b1;
            tgt_nxt = pc_r + imm_j;
          end
          OP_JALR: begin
            if (f3 != 3'd0) begin
              st_nxt = ST_ILLEGAL;
            end else begin
              val_nxt = pc_r + 32'd4;
              wr_nxt  = 1'b1;
              tgt_nxt = (a + imm_i) & ~32'd1;
            end
          end
          OP_BRANCH: begin
            case (f3)
              3'd0: if (a == b) tgt_nxt = pc_r + imm_b;
              3'd1: if (a != b) tgt_nxt = pc_r + imm_b;
              3'd4: if ($signed(a) < $signed(b)) tgt_nxt = pc_r + imm_b;
              3'd5: if ($signed(a) >= $signed(b)) tgt_nxt = pc_r + imm_b;
              3'd6: if (a < b) tgt_nxt = pc_r + imm_b;
              3'd7: if (a >= b) tgt_nxt = pc_r + imm_b;
              default: st_nxt = ST_ILLEGAL;
            endcase
          end
          OP_AMO: begin
            if (f3 != 3'd2) begin
              st_nxt = ST_ILLEGAL;
            end else begin
              case (f5) inside
                AMO_ADD, AMO_SWAP, AMO_LR, AMO_SC, AMO_XOR, AMO_OR, AMO_AND,
                AMO_MIN, AMO_MAX, AMO_MINU, AMO_MAXU: begin
                  if (!mem_ok) begin
                    st_nxt = ST_FAULT;
                    if (f5 == AMO_SC) begin
                      resv_v_nxt = 1'b0;
                    end
                  end else begin
                    state_nxt = S_MEM;
                  end
                end
                default: st_nxt = ST_ILLEGAL;
              endcase
            end
          end
          OP_FENCE: begin
            if (f3 > 3'd1) begin
              st_nxt = ST_ILLEGAL;
            end
          end
          OP_SYSTEM: begin
            if (f3 == 3'd0) begin
              if (is_ecall) begin
                st_nxt = (a == PASS_CODE) ? ST_PASS : ST_FAIL;
              end
            end else if (f3 == 3'd4) begin
              st_nxt = ST_ILLEGAL;
            end else begin
              state_nxt = S_MEM;
            end
          end
          default: begin
            st_nxt = ST_ILLEGAL;
          end
        endcase
      end
      S_MEM: begin
        state_nxt = S_WB;
        wr_nxt    = 1'b1;
        if (opc == OP_LOAD) begin
          case (f3)
            3'd0:    val_nxt = {{24{ld_sh[7]}}, ld_sh[7:0]};
            3'd1:    val_nxt = {{16{ld_sh[15]}}, ld_sh[15:0]};
            3'd4:    val_nxt = {24'd0, ld_sh[7:0]};
            3'd5:    val_nxt = {16'd0, ld_sh[15:0]};
            default: val_nxt = ld_sh;
          endcase
        end else if (opc == OP_STORE) begin
          wr_nxt = 1'b0;
          dm_we  = 1'b1;
        end else if (opc == OP_AMO) begin
          if (f5 == AMO_LR) begin
            val_nxt    = dm_q;
            resv_v_nxt = 1'b1;
            resv_a_nxt = mem_addr;
          end else if (f5 == AMO_SC) begin
            resv_v_nxt = 1'b0;
            if (resv_v_r && (resv_a_r == mem_addr)) begin
              dm_we    = 1'b1;
              dm_wdata = b;
              val_nxt  = 32'd0;
            end else begin
              val_nxt = 32'd1;
            end
          end else begin
            dm_we    = 1'b1;
            dm_wdata = amo_new;
            val_nxt  = dm_q;
          end
        end else begin
          // CSR read-modify-write
          val_nxt = csr_old;
          if ((f3[1:0] == 2'd1) || (rs1 != 5'd0)) begin
            if (csr_idx == CSR_CYCLE) begin
              cycle_nxt = csr_new;
            end else begin
              csr_we = 1'b1;
            end
          end
        end
      end
      S_DIV: begin
        if (!dtrial[33]) begin
          dr_nxt = dtrial[31:0];
          dq_nxt = {dq_r[30:0], 1'b1};
        end else begin
          dr_nxt = {dr_r[30:0], dq_r[31]};
          dq_nxt = {dq_r[30:0], 1'b0};
        end
        dcnt_nxt = dcnt_r + 5'd1;
        if (dcnt_r == 5'd31) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (f3[2]) begin
          val_nxt = div_res;
        end else if (f3 == 3'd0) begin
          val_nxt = prod_r[31:0];
        end else begin
          val_nxt = prod_r[63:32];
        end
        wr_nxt    = 1'b1;
        state_nxt = S_WB;
      end
      S_WB: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_pc_nxt    = pc_r;
          out_npc_nxt   = tgt_r;
          out_wr_nxt    = wr_r && (rd != 5'd0);
          out_idx_nxt   = (wr_r && (rd != 5'd0)) ? rd : 5'd0;
          out_val_nxt   = (wr_r && (rd != 5'd0)) ? val_r : 32'd0;
          out_st_nxt    = st_r;
          if (wr_r && (rd != 5'd0)) begin
            rf_we          = 1'b1;
            rf_vld_nxt[rd] = 1'b1;
          end
          pc_nxt    = tgt_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_we) begin
      if (cfg_index == CFG_START) begin
        start_nxt = cfg_wdata;
        pc_nxt    = cfg_wdata;
      end else begin
        base_nxt = cfg_wdata;
      end
    end
  end

  // memories: registered reads every cycle, one write port each
  always_ff @(posedge clk) begin
    rfa_q <= rf_mem[ra_addr];
    rfb_q <= rf_mem[rs2];
    if (rf_we) begin
      rf_mem[rf_waddr] <= rf_wdata;
    end
  end

  always_ff @(posedge clk) begin
    csr_q <= csr_mem[csr_idx];
    if (csr_we) begin
      csr_mem[csr_waddr] <= csr_wdata;
    end
  end

  always_ff @(posedge clk) begin
    dm_q <= dmem[widx];
    if (dm_we) begin
      dmem[dm_waddr] <= dm_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      pc_r        <= 32'd0;
      start_r     <= 32'd0;
      base_r      <= 32'd0;
      cycle_r     <= 32'd0;
      resv_v_r    <= 1'b0;
      resv_a_r    <= 32'd0;
      rf_vld_r    <= '0;
      rfa_v       <= 1'b0;
      rfb_v       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      pc_r        <= pc_nxt;
      start_r     <= start_nxt;
      base_r      <= base_nxt;
      cycle_r     <= cycle_nxt;
      resv_v_r    <= resv_v_nxt;
      resv_a_r    <= resv_a_nxt;
      rf_vld_r    <= rf_vld_nxt;
      rfa_v       <= rf_vld_r[ra_addr];
      rfb_v       <= rf_vld_r[rs2];
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    instr_r   <= instr_nxt;
    val_r     <= val_nxt;
    tgt_r     <= tgt_nxt;
    st_r      <= st_nxt;
    wr_r      <= wr_nxt;
    prod_r    <= prod_nxt;
    dq_r      <= dq_nxt;
    dr_r      <= dr_nxt;
    dd_r      <= dd_nxt;
    dna_r     <= dna_nxt;
    dnb_r     <= dnb_nxt;
    dcnt_r    <= dcnt_nxt;
    out_pc_r  <= out_pc_nxt;
    out_npc_r <= out_npc_nxt;
    out_val_r <= out_val_nxt;
    out_wr_r  <= out_wr_nxt;
    out_idx_r <= out_idx_nxt;
    out_st_r  <= out_st_nxt;
  end

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_instr_pc   = out_pc_r;
  assign out_next_pc    = out_npc_r;
  assign out_rd_written = out_wr_r;
  assign out_rd_index   = out_idx_r;
  assign out_rd_value   = out_val_r;
  assign out_status     = out_st_r;

endmodule

// File: tb/tb.sv
// Self-checking testbench for the RV32IMA instruction executor.
`timescale 1ns / 1ps

module tb;
  import rvie_pkg::*;

  localparam int          DATA_WORDS = 4096;
  localparam logic [31:0] WIN_BYTES  = 32'd16384;
  localparam int          CYCLE_LIMIT = 1000000;
  localparam int          DRAIN_CYCLES = 60;

  typedef struct packed {
    logic [31:0] ipc;
    logic [31:0] npc;
    logic        wr;
    logic [4:0]  rd;
    logic [31:0] val;
    logic [2:0]  st;
  } retire_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [31:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_instr;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_instr_pc;
  logic [31:0] out_next_pc;
  logic        out_rd_written;
  logic [4:0]  out_rd_index;
  logic [31:0] out_rd_value;
  logic [2:0]  out_status;

  rv32ima_instruction_execute #(.DATA_WORDS(DATA_WORDS)) DUT (.*);

  // hart shadow state for the predictor
  logic [31:0] pc_q;
  logic [31:0] win_base;
  logic [31:0] gpr [32];
  logic [31:0] csr_mem [4096];
  logic [31:0] dmem [DATA_WORDS];
  logic        resv_ok;
  logic [31:0] resv_at;

  logic [31:0] instr_q [$];     // pending instruction words
  retire_t     retire_q [$];    // expected retirements, oldest first
  int errors = 0;
  int n_in = 0;
  int n_out = 0;
  int cycles = 0;
  bit taken = 0;
  bit held = 0;
  int hold_cnt = 0;
  logic calm;

  // no idling on either side for a stretch in the middle of the run
  assign calm = (n_in >= 500) && (n_in < 700);

  always #10 clk = ~clk;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
    $display("MISMATCH %s: got %h exp %h (result %0d)", what, got, exp, n_out);
    errors++;
  endtask

  // ---------------------------------------------------------------- predictor
  function automatic logic [31:0] alu(input logic [2:0] f3, input logic alt,
                                      input logic [31:0] a, input logic [31:0] b);
    logic [4:0] sh;
    sh = b[4:0];
    case (f3)
      3'd0: return alt ? a - b : a + b;
      3'd1: return a << sh;
      3'd2: return {31'b0, $signed(a) < $signed(b)};
      3'd3: return {31'b0, a < b};
      3'd4: return a ^ b;
      3'd5: return alt ? 32'($signed(a) >>> sh) : a >> sh;
      3'd6: return a | b;
      default: return a & b;
    endcase
  endfunction

  function automatic logic [31:0] muldiv(input logic [2:0] f3, input logic [31:0] a,
                                         input logic [31:0] b);
    logic [63:0] p;
    logic [31:0] ua, ub, q, r;
    logic na, nb;
    case (f3)
      3'd0: return a * b;
      3'd1: begin
        p = {{32{a[31]}}, a} * {{32{b[31]}}, b};
        return p[63:32];
      end
      3'd2: begin
        p = {{32{a[31]}}, a} * {32'b0, b};
        return p[63:32];
      end
      3'd3: begin
        p = {32'b0, a} * {32'b0, b};
        return p[63:32];
      end
      default: begin
        // divide by zero: all ones for quotient, dividend for remainder
        if (b == 0) return f3[1] ? a : 32'hFFFF_FFFF;
        na = !f3[0] && a[31];
        nb = !f3[0] && b[31];
        ua = na ? -a : a;
        ub = nb ? -b : b;
        q = ua / ub;
        r = ua % ub;
        if (f3[1]) return na ? -r : r;
        return (na != nb) ? -q : q;
      end
    endcase
  endfunction

  function automatic logic mem_ok(input logic [31:0] addr, input logic [31:0] sz);
    return ((addr & (sz - 1)) == 0) && ((addr - win_base) < WIN_BYTES);
  endfunction

  function automatic logic [31:0] mem_rd(input logic [31:0] addr, input logic [31:0] sz);
    logic [31:0] off, m;
    off = addr - win_base;
    m = (sz == 4) ? 32'hFFFF_FFFF : ((32'd1 << (sz * 8)) - 1);
    return (dmem[off[13:2]] >> (off[1:0] * 8)) & m;
  endfunction

  function automatic void mem_wr(input logic [31:0] addr, input logic [31:0] sz,
                                 input logic [31:0] v);
    logic [31:0] off, m;
    off = addr - win_base;
    m = ((sz == 4) ? 32'hFFFF_FFFF : ((32'd1 << (sz * 8)) - 1)) << (off[1:0] * 8);
    dmem[off[13:2]] = (dmem[off[13:2]] & ~m) | ((v << (off[1:0] * 8)) & m);
  endfunction

  function automatic retire_t execute(input logic [31:0] ins);
    retire_t r;
    logic [6:0] op, f7;
    logic [4:0] rd, r1, r2, f5;
    logic [2:0] f3;
    logic [31:0] a, b, imm_i, addr, imm, old, nv, sz, src;
    logic wr, take, lt;
    op = ins[6:0]; rd = ins[11:7]; f3 = ins[14:12];
    r1 = ins[19:15]; r2 = ins[24:20]; f7 = ins[31:25]; f5 = ins[31:27];
    a = gpr[r1]; b = gpr[r2];
    imm_i = {{20{ins[31]}}, ins[31:20]};
    r = '0;
    r.ipc = pc_q;
    r.npc = pc_q + 4;
    r.st = ST_OK;
    wr = 0;
    csr_mem[CSR_CYCLE] = csr_mem[CSR_CYCLE] + 1;
    case (op)
      OP_LUI: begin r.val = ins & UPPER_MASK; wr = 1; end
      OP_AUIPC: begin r.val = pc_q + (ins & UPPER_MASK); wr = 1; end
      OP_OP: begin
        wr = 1;
        if (f7 == F7_MULDIV) r.val = muldiv(f3, a, b);
        else if (f7 == F7_BASE) r.val = alu(f3, 1'b0, a, b);
        else if (f7 == F7_ALT && (f3 == 3'd0 || f3 == 3'd5)) r.val = alu(f3, 1'b1, a, b);
        else begin wr = 0; r.st = ST_ILLEGAL; end
      end
      OP_IMM: begin
        if (f3 == 3'd1 || f3 == 3'd5) begin
          // shift immediates: only SRAI may carry a nonzero upper field
          if (f7 != F7_BASE && !(f3 == 3'd5 && f7 == F7_ALT)) r.st = ST_ILLEGAL;
          else begin r.val = alu(f3, f7 == F7_ALT, a, {27'b0, r2}); wr = 1; end
        end else begin
          r.val = alu(f3, 1'b0, a, imm_i); wr = 1;
        end
      end
      OP_LOAD: begin
        sz = 32'd1 << f3[1:0];
        addr = a + imm_i;
        if (f3 == 3'd3 || f3 >= 3'd6) r.st = ST_ILLEGAL;
        else if (!mem_ok(addr, sz)) r.st = ST_FAULT;
        else begin
          r.val = mem_rd(addr, sz);
          if (f3 == 3'd0 && r.val[7]) r.val |= 32'hFFFF_FF00;
          if (f3 == 3'd1 && r.val[15]) r.val |= 32'hFFFF_0000;
          wr = 1;
        end
      end
      OP_STORE: begin
        sz = 32'd1 << f3[1:0];
        addr = a + {{20{ins[31]}}, ins[31:25], ins[11:7]};
        if (f3 > 3'd2) r.st = ST_ILLEGAL;
        else if (!mem_ok(addr, sz)) r.st = ST_FAULT;
        else mem_wr(addr, sz, b);
      end
      OP_JAL: begin
        imm = {{12{ins[31]}}, ins[19:12], ins[20], ins[30:21], 1'b0};
        r.val = pc_q + 4; wr = 1; r.npc = pc_q + imm;
      end
      OP_JALR: begin
        if (f3 != 3'd0) r.st = ST_ILLEGAL;
        else begin r.val = pc_q + 4; wr = 1; r.npc = (a + imm_i) & ~32'd1; end
      end
      OP_BRANCH: begin
        imm = {{20{ins[31]}}, ins[7], ins[30:25], ins[11:8], 1'b0};
        take = 0;
        case (f3)
          3'd0: take = a == b;
          3'd1: take = a != b;
          3'd4: take = $signed(a) < $signed(b);
          3'd5: take = $signed(a) >= $signed(b);
          3'd6: take = a < b;
          3'd7: take = a >= b;
          default: r.st = ST_ILLEGAL;
        endcase
        if (take) r.npc = pc_q + imm;
      end
      OP_AMO: begin
        if (f3 != 3'd2) r.st = ST_ILLEGAL;
        else if (!(f5 inside {AMO_ADD, AMO_SWAP, AMO_LR, AMO_SC, AMO_XOR, AMO_OR, AMO_AND,
                              AMO_MIN, AMO_MAX, AMO_MINU, AMO_MAXU})) r.st = ST_ILLEGAL;
        else if (!mem_ok(a, 4)) begin
          r.st = ST_FAULT;
          if (f5 == AMO_SC) resv_ok = 0;
        end else begin
          wr = 1;
          if (f5 == AMO_LR) begin
            r.val = mem_rd(a, 4); resv_ok = 1; resv_at = a;
          end else if (f5 == AMO_SC) begin
            if (resv_ok && resv_at == a) begin mem_wr(a, 4, b); r.val = 0; end
            else r.val = 1;
            resv_ok = 0;
          end else begin
            old = mem_rd(a, 4);
            lt = $signed(old) < $signed(b);
            case (f5)
              AMO_SWAP: nv = b;
              AMO_ADD:  nv = old + b;
              AMO_XOR:  nv = old ^ b;
              AMO_AND:  nv = old & b;
              AMO_OR:   nv = old | b;
              AMO_MIN:  nv = lt ? old : b;
              AMO_MAX:  nv = lt ? b : old;
              AMO_MINU: nv = (old < b) ? old : b;
              default:  nv = (old < b) ? b : old;
            endcase
            mem_wr(a, 4, nv);
            r.val = old;
          end
        end
      end
      OP_FENCE: if (f3 > 3'd1) r.st = ST_ILLEGAL;
      OP_SYSTEM: begin
        if (f3 == 3'd0) begin
          // ECALL reports on a0; EBREAK and friends do nothing
          if (ins[31:20] == 0) r.st = (gpr[REG_A0] == PASS_CODE) ? ST_PASS : ST_FAIL;
        end else if (f3 == 3'd4) r.st = ST_ILLEGAL;
        else begin
          src = f3[2] ? {27'b0, r1} : a;
          old = csr_mem[ins[31:20]];
          if (f3[1:0] == 2'd1) csr_mem[ins[31:20]] = src;
          else if (r1 != 0) csr_mem[ins[31:20]] = (f3[1:0] == 2'd2) ? (old | src) : (old & ~src);
          r.val = old; wr = 1;
        end
      end
      default: r.st = ST_ILLEGAL;
    endcase
    pc_q = r.npc;
    if (wr && rd != 0) begin
      gpr[rd] = r.val;
      r.wr = 1;
      r.rd = rd;
    end else r.val = 0;
    return r;
  endfunction

  // ------------------------------------------------------------- encoders
  function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [4:0] rs2,
      input logic [4:0] rs1, input logic [2:0] f3, input logic [4:0] rd, input logic [6:0] op);
    return {f7, rs2, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] enc_i(input logic [11:0] imm, input logic [4:0] rs1,
      input logic [2:0] f3, input logic [4:0] rd, input logic [6:0] op);
    return {imm, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] enc_s(input logic [11:0] imm, input logic [4:0] rs2,
      input logic [4:0] rs1, input logic [2:0] f3);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], OP_STORE};
  endfunction

  function automatic logic [31:0] enc_b(input logic [12:0] imm, input logic [4:0] rs2,
      input logic [4:0] rs1, input logic [2:0] f3);
    return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OP_BRANCH};
  endfunction

  function automatic logic [31:0] enc_j(input logic [20:0] imm, input logic [4:0] rd);
    return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OP_JAL};
  endfunction

  function automatic logic [31:0] enc_amo(input logic [4:0] f5, input logic [4:0] rs2,
      input logic [4:0] rs1, input logic [4:0] rd);
    return {f5, 2'($urandom), rs2, rs1, 3'd2, rd, OP_AMO};
  endfunction

  // LUI + ADDI pair that loads a full 32-bit constant
  task automatic load_const(input logic [4:0] rd, input logic [31:0] v);
    logic [31:0] hi, lo;
    hi = (v + 32'h800) & UPPER_MASK;
    lo = v - hi;
    instr_q.push_back({hi[31:12], rd, OP_LUI});
    instr_q.push_back(enc_i(lo[11:0], rd, 3'd0, rd, OP_IMM));
  endtask

  // x1 points 2 KiB into the window so signed offsets reach the first 4 KiB
  function automatic logic [11:0] window_imm(input logic [31:0] sz);
    logic [31:0] addr;
    addr = win_base + (($urandom_range(0, 3) == 0) ? $urandom_range(4, 4095)
                                                   : $urandom_range(4, 515));
    addr = addr & ~(sz - 1);
    return 12'(addr - (win_base + 32'd2048));
  endfunction

  task automatic directed_items();
    instr_q.push_back(enc_i(12'd42, 5'd0, 3'd0, REG_A0, OP_IMM));
    instr_q.push_back(32'h0000_0073);                                 // ECALL, a0 = 42
    instr_q.push_back(enc_i(12'h800, 5'd0, 3'd0, REG_A0, OP_IMM));
    instr_q.push_back(32'h0000_0073);                                 // ECALL, other a0
    instr_q.push_back(32'h0010_0073);                                 // EBREAK: no-op
    instr_q.push_back({20'hFFFFF, 5'd31, OP_LUI});
    instr_q.push_back(enc_i(12'h7FF, 5'd0, 3'd0, 5'd3, OP_IMM));
    instr_q.push_back({20'h80000, 5'd4, OP_LUI});
    instr_q.push_back(enc_i(12'hFFF, 5'd0, 3'd0, 5'd5, OP_IMM));
    instr_q.push_back(enc_r(F7_MULDIV, 5'd5, 5'd4, 3'd4, 5'd6, OP_OP));  // signed overflow
    instr_q.push_back(enc_r(F7_MULDIV, 5'd5, 5'd4, 3'd6, 5'd7, OP_OP));
    instr_q.push_back(enc_r(F7_MULDIV, 5'd0, 5'd4, 3'd5, 5'd8, OP_OP));  // divide by zero
    instr_q.push_back(enc_r(F7_MULDIV, 5'd0, 5'd4, 3'd7, 5'd9, OP_OP));
    instr_q.push_back(enc_r(F7_MULDIV, 5'd5, 5'd4, 3'd1, 5'd11, OP_OP));
    instr_q.push_back(enc_r(F7_ALT, 5'd5, 5'd4, 3'd5, 5'd15, OP_OP));    // SRA by 31
    instr_q.push_back(enc_r(F7_MULDIV, 5'd3, 5'd3, 3'd1, 5'd16, OP_IMM)); // reserved shift
    instr_q.push_back(enc_s(12'd0, 5'd31, 5'd1, 3'd2));
    instr_q.push_back(enc_i(12'd2, 5'd1, 3'd1, 5'd17, OP_LOAD));        // LH sign extend
    instr_q.push_back(enc_i(12'd1, 5'd1, 3'd2, 5'd19, OP_LOAD));        // misaligned
    instr_q.push_back(enc_i(12'd0, 5'd0, 3'd2, 5'd20, OP_LOAD));        // outside window
    instr_q.push_back(enc_amo(AMO_LR, 5'd0, 5'd1, 5'd21));
    instr_q.push_back(enc_amo(AMO_SC, 5'd3, 5'd1, 5'd22));              // succeeds
    instr_q.push_back(enc_amo(AMO_SC, 5'd3, 5'd1, 5'd23));              // reservation gone
    instr_q.push_back(enc_amo(AMO_SWAP, 5'd5, 5'd1, 5'd24));
    instr_q.push_back(enc_i(12'h300, 5'd4, 3'd1, 5'd25, OP_SYSTEM));    // CSRRW
    instr_q.push_back(enc_i(CSR_CYCLE, 5'd0, 3'd2, 5'd26, OP_SYSTEM));  // read cycle
    instr_q.push_back(enc_i(12'd0, 5'd0, 3'd0, 5'd0, OP_FENCE));
    instr_q.push_back(32'h0000_0000);
    instr_q.push_back(32'hFFFF_FFFF);
    instr_q.push_back(enc_j(21'h1FFFFC, 5'd28));
    instr_q.push_back(enc_i(12'd0, 5'd3, 3'd0, 5'd29, OP_JALR));         // odd target
    instr_q.push_back(enc_b(13'd8, 5'd0, 5'd0, 3'd0));
  endtask

  // one random instruction or short well-formed sequence
  task automatic random_item();
    logic [4:0] rd, rs1, rs2;
    logic [2:0] f3;
    logic [4:0] f5;
    logic [11:0] imm;
    logic [6:0] ops [12];
    int pick;
    ops = '{OP_LUI, OP_AUIPC, OP_OP, OP_IMM, OP_LOAD, OP_STORE, OP_JAL, OP_JALR,
            OP_BRANCH, OP_AMO, OP_FENCE, OP_SYSTEM};
    rd = 5'($urandom_range(2, 31));
    rs1 = 5'($urandom);
    rs2 = 5'($urandom);
    f3 = 3'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 5) instr_q.push_back($urandom);
    else if (pick < 12) instr_q.push_back({25'($urandom), ops[$urandom_range(0, 11)]});
    else if (pick < 30) begin
      case ($urandom_range(0, 2))
        0: instr_q.push_back(enc_r(F7_BASE, rs2, rs1, f3, rd, OP_OP));
        1: instr_q.push_back(enc_r(F7_MULDIV, rs2, rs1, f3, rd, OP_OP));
        default: instr_q.push_back(enc_r(F7_ALT, rs2, rs1, $urandom_range(0, 1) ? 3'd0 : 3'd5,
                                         rd, OP_OP));
      endcase
    end else if (pick < 40) begin
      if (f3 == 3'd1 || f3 == 3'd5)
        instr_q.push_back(enc_r($urandom_range(0, 5) == 0 ? 7'($urandom)
                                : (f3 == 3'd5 && $urandom_range(0, 1)) ? F7_ALT : F7_BASE,
                                rs2, rs1, f3, rd, OP_IMM));
      else instr_q.push_back(enc_i(12'($urandom), rs1, f3, rd, OP_IMM));
    end else if (pick < 55) begin
      f3 = 3'($urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 2) | ($urandom_range(0, 1) << 2));
      if (f3 == 3'd6 && $urandom_range(0, 3) != 0) f3 = 3'd2;
      imm = window_imm(32'd1 << f3[1:0]);
      if ($urandom_range(0, 7) == 0) imm = imm + 12'($urandom_range(1, 3));
      rs1 = ($urandom_range(0, 9) == 0) ? 5'd0 : 5'd1;
      if ($urandom_range(0, 1)) instr_q.push_back(enc_i(imm, rs1, f3, rd, OP_LOAD));
      else instr_q.push_back(enc_s(imm, rs2, rs1, f3[2] ? 3'($urandom) : f3));
    end else if (pick < 65) begin
      imm = window_imm(32'd4);
      instr_q.push_back(enc_i(imm, 5'd1, 3'd0, 5'd2, OP_IMM));
      if ($urandom_range(0, 2) == 0) begin
        instr_q.push_back(enc_amo(AMO_LR, 5'd0, 5'd2, rd));
        if ($urandom_range(0, 3) == 0) instr_q.push_back(enc_i(12'd4, 5'd2, 3'd0, 5'd2, OP_IMM));
        instr_q.push_back(enc_amo(AMO_SC, rs2, 5'd2, rd));
      end else begin
        case ($urandom_range(0, 9))
          0: f5 = AMO_ADD;  1: f5 = AMO_SWAP; 2: f5 = AMO_XOR;  3: f5 = AMO_OR;
          4: f5 = AMO_AND;  5: f5 = AMO_MIN;  6: f5 = AMO_MAX;  7: f5 = AMO_MINU;
          8: f5 = AMO_MAXU;
          default: f5 = 5'($urandom);
        endcase
        instr_q.push_back(enc_amo(f5, rs2, 5'd2, rd));
      end
    end else if (pick < 73) begin
      case ($urandom_range(0, 2))
        0: instr_q.push_back(enc_b(13'($urandom), rs2, rs1, f3));
        1: instr_q.push_back(enc_j(21'($urandom), rd));
        default: instr_q.push_back(enc_i(12'($urandom), rs1, 3'($urandom_range(0, 3) == 0
                                         ? $urandom : 0), rd, OP_JALR));
      endcase
    end else if (pick < 83) begin
      imm = $urandom_range(0, 2) == 0 ? CSR_CYCLE : 12'($urandom_range(0, 7) | 12'h340);
      if ($urandom_range(0, 5) == 0) imm = 12'($urandom);
      if ($urandom_range(0, 3) == 0) rs1 = 5'd0;
      instr_q.push_back(enc_i(imm, rs1, f3 == 3'd0 ? 3'd2 : f3, rd, OP_SYSTEM));
    end else if (pick < 88)
      instr_q.push_back({20'($urandom), rd, $urandom_range(0, 1) ? OP_LUI : OP_AUIPC});
    else if (pick < 94) begin
      case ($urandom_range(0, 3))
        0: instr_q.push_back(enc_i(PASS_CODE[11:0], 5'd0, 3'd0, REG_A0, OP_IMM));
        1: instr_q.push_back(32'h0000_0073);
        2: instr_q.push_back({12'($urandom), 13'd0, OP_SYSTEM});
        default: instr_q.push_back(enc_i(12'($urandom), rs1, 3'($urandom), 5'($urandom),
                                         OP_FENCE));
      endcase
    end else load_const(5'd1, win_base + 32'd2048);
  endtask

  // ------------------------------------------------------------- stimulus
  task automatic wait_idle();
    while (!(instr_q.size() == 0 && !in_valid && retire_q.size() == 0)) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic idx, input logic [31:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    if (idx == CFG_START) pc_q = v;
    else win_base = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [31:0] boot [4];
    logic [31:0] base [4];
    int target;
    clk = 0; rst_n = 0;
    cfg_we = 0; cfg_index = 0; cfg_wdata = 0;
    in_valid = 0; in_instr = 0; out_stall = 0;
    pc_q = 0; win_base = 0; resv_ok = 0; resv_at = 0;
    foreach (gpr[i]) gpr[i] = 0;
    foreach (csr_mem[i]) csr_mem[i] = 0;
    foreach (dmem[i]) dmem[i] = 0;
    boot = '{32'h8000_0000, 32'hFFFF_FFFC, 32'h0000_0000, $urandom};
    base = '{32'h0001_0000, 32'hFFFF_C000, 32'h0000_0000, $urandom};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    for (int p = 0; p < 4; p++) begin
      wait_idle();
      write_cfg(CFG_START, boot[p]);
      write_cfg(CFG_BASE, base[p]);
      load_const(5'd1, win_base + 32'd2048);
      if (p == 0) directed_items();
      target = instr_q.size() + 250;
      while (instr_q.size() < target) random_item();
    end
    wait_idle();
    foreach (retire_q[i]) report("missing result, pc", 32'h0, retire_q[i].ipc);
    $display("tb: %0d instructions retired over 4 boot/window settings, %0d cycles",
             n_out, cycles);
    $display("tb: long output hold-off applied: %0d", held);
    if (errors == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end

  // ------------------------------------------------------------- driver
  always @(negedge clk) begin
    if (rst_n && (!in_valid || taken)) begin
      taken = 0;
      if (instr_q.size() != 0 && (calm || $urandom_range(0, 99) >= 38)) begin
        in_instr <= instr_q.pop_front();
        in_valid <= 1'b1;
      end else in_valid <= 1'b0;
    end
  end

  // result-side stall, with one long hold-off to back the pipeline up
  always @(negedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else if (!held && n_in >= 300) begin
      held = 1;
      hold_cnt = 400;
      out_stall <= 1'b1;
    end else out_stall <= !calm && ($urandom_range(0, 99) < 38);
  end

  // ------------------------------------------------------------- monitor
  always @(posedge clk) begin
    retire_t exp;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: timeout after %0d cycles", cycles);
      $display("tb: done, errors");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (retire_q.size() == 0) report("unexpected transaction, pc", out_instr_pc, 32'h0);
      else begin
        exp = retire_q.pop_front();
        if (out_instr_pc != exp.ipc) report("instr_pc", out_instr_pc, exp.ipc);
        if (out_next_pc != exp.npc) report("next_pc", out_next_pc, exp.npc);
        if (out_rd_written != exp.wr) report("rd_written", out_rd_written, exp.wr);
        if (out_rd_index != exp.rd) report("rd_index", out_rd_index, exp.rd);
        if (out_rd_value != exp.val) report("rd_value", out_rd_value, exp.val);
        if (out_status != exp.st) report("status", out_status, exp.st);
      end
      n_out++;
    end
    // predict after the check so a same-edge result never pairs with this input
    if (rst_n && in_valid && !in_stall) begin
      retire_q.push_back(execute(in_instr));
      n_in++;
      taken = 1;
    end
  end

endmodule

// File: rv32ima_instruction_execute.f
hdl/rvie_pkg.sv
hdl/rv32ima_instruction_execute.sv
tb/tb.sv
